// ===== hw/rtl/jpegls_run_mode_encoder_core_macros.svh =====
// Assertion helpers used by the encoder core RTL.
`ifndef JPEGLS_RUN_MODE_ENCODER_CORE_MACROS_SVH
`define JPEGLS_RUN_MODE_ENCODER_CORE_MACROS_SVH

`define JRM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define JRM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/jrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package jrm_pkg;

	localparam int unsigned SAMPLE_BITS = 8;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_RANGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BITS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HALVE_THR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_INIT = 3'd6;
	localparam int unsigned CFG_DATA_W = 9;

	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
	localparam int unsigned K_MAX = 31;

	typedef struct packed {
		logic       action;
		logic [7:0] sample;
		logic [7:0] left_neighbor;
		logic [7:0] above_neighbor;
		logic       run_start;
		logic       end_of_line;
	} in_word_t;

	typedef struct packed {
		logic [31:0] code_bits;
		logic [5:0]  code_length;
		logic [7:0]  recon;
		logic        run_ended;
		logic        last;
	} out_word_t;

	function automatic logic [3:0] order_j(input logic [4:0] idx);
		logic [3:0] r;
		unique case (idx)
			5'd0, 5'd1, 5'd2, 5'd3:     r = 4'd0;
			5'd4, 5'd5, 5'd6, 5'd7:     r = 4'd1;
			5'd8, 5'd9, 5'd10, 5'd11:   r = 4'd2;
			5'd12, 5'd13, 5'd14, 5'd15: r = 4'd3;
			5'd16, 5'd17: r = 4'd4;
			5'd18, 5'd19: r = 4'd5;
			5'd20, 5'd21: r = 4'd6;
			5'd22, 5'd23: r = 4'd7;
			default: r = 4'(idx - 5'd16);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/jrm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module jrm_divider
	import jrm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [9:0]  dividend,
	input  wire logic [8:0]  divisor,
	output logic             done,
	output logic [9:0]       quotient
);
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  rem_q;
	logic [9:0]  quo_q;
	logic [10:0] trial;

	assign trial = {rem_q, quo_q[9]} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd9) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[10]) begin
				rem_q <= trial[9:0];
				quo_q <= {quo_q[8:0], 1'b1};
			end else begin
				rem_q <= {rem_q[8:0], quo_q[9]};
				quo_q <= {quo_q[8:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/jpegls_run_mode_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Run sample: after accept, S_RUN registers the word unless the output is stalled and
// returns to S_IDLE, so ready rises as the word turns valid. Interruption sample: S_ERR,
// S_DIV (serial divider, near > 0 only), S_MOD, S_KSRCH (k is the Golomb parameter, found
// one compare per cycle), S_CODE, then the tail word from S_OUT1 and the Golomb word from
// S_OUT2, each held while stalled. Start of scan: no word. Reset (arst_n low) clears the
// FSM, run and context state, loads default register values; ready right after reset.
module jpegls_run_mode_encoder_core
	import jrm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
`include "jpegls_run_mode_encoder_core_macros.svh"

	localparam logic [7:0] SMASK = 8'((17'd1 << SAMPLE_BITS) - 17'd1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RUN   = 9'b000000010,
		S_ERR   = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_MOD   = 9'b000010000,
		S_KSRCH = 9'b000100000,
		S_CODE  = 9'b001000000,
		S_OUT1  = 9'b010000000,
		S_OUT2  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [7:0] near_q, max_value_q, halve_q, accum_init_q;
	logic [8:0] err_range_q;
	logic [4:0] quant_bits_q;
	logic [6:0] code_limit_q;

	logic [7:0]  run_value_q;
	logic [15:0] run_count_q;
	logic [4:0]  run_index_q;
	logic [23:0] esum_q [2];
	logic [7:0]  occ_q [2];
	logic [7:0]  neg_q [2];

	in_word_t    in_q;
	logic [7:0]  ix, ra, rb;
	logic        ri_q, neg_sign_q;
	logic signed [10:0] err_q;
	logic [3:0]  jv_q;
	logic [4:0]  k_q;
	logic [24:0] temp_q;
	logic [31:0] occ_sh_q;
	logic [8:0]  em_q;
	logic signed [10:0] rx_q;
	out_word_t   out_q;
	out_word_t   tail_q, gcode_q;
	logic        out_valid_q;

	logic        div_start, div_done;
	logic [9:0]  div_dividend, div_quot;
	logic [8:0]  div_d;

	assign ix = in_q.sample & SMASK;
	assign ra = in_q.left_neighbor & SMASK;
	assign rb = in_q.above_neighbor & SMASK;
	assign div_d = {near_q, 1'b1};

	jrm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_quot)
	);

	logic [10:0] abs_err;
	assign abs_err = err_q[10] ? 11'(-err_q) : 11'(err_q);
	assign div_dividend = 10'(abs_err + {3'd0, near_q});
	assign div_start = (state_q == S_ERR) && (near_q != 8'd0);

	// combinational helpers
	logic [7:0]  rv_eff;
	logic [8:0]  adiff;
	logic        match;
	logic [16:0] cnt_inc;
	logic [16:0] jpow;
	logic        run_roll, run_bit;
	logic [16:0] cnt_left;
	assign rv_eff  = in_q.run_start ? ra : run_value_q;
	assign adiff   = (ix > rv_eff) ? 9'(ix - rv_eff) : 9'(rv_eff - ix);
	assign match   = adiff <= {1'b0, near_q};
	assign cnt_inc = {1'b0, (in_q.run_start ? 16'd0 : run_count_q) + 16'd1};
	assign jpow    = 17'd1 << order_j(run_index_q);
	assign run_roll = cnt_inc >= jpow;
	assign cnt_left = run_roll ? cnt_inc - jpow : cnt_inc;
	assign run_bit  = run_roll || (in_q.end_of_line && cnt_left != 17'd0);

	logic        emit_c;
	assign emit_c = (state_q == S_OUT1 || state_q == S_OUT2 || (state_q == S_RUN && match))
		&& (!out_valid_q || out_ready);

	logic        qc;
	assign qc = ri_q;

	// mapping / code computation
	logic        map;
	logic signed [11:0] m_val;
	logic [8:0]  em_c;
	logic signed [8:0] t_val;
	logic [8:0]  em_k;
	logic [4:0]  w_sel;
	logic [31:0] p_sel, word;
	logic [7:0]  glen;
	logic [6:0]  u_sel;
	logic [8:0]  nx2;
	assign nx2 = {neg_q[qc], 1'b0};
	always_comb begin
		if (k_q == 5'd0 && err_q > 0 && nx2 < {1'b0, occ_q[qc]}) map = 1'b1;
		else if (err_q < 0 && nx2 >= {1'b0, occ_q[qc]}) map = 1'b1;
		else if (err_q < 0 && k_q != 5'd0) map = 1'b1;
		else map = 1'b0;
		m_val = 12'sd2 * 12'(abs_err) - 12'(ri_q) - 12'(map);
		em_c  = m_val < 0 ? 9'd0 : 9'(m_val);
	end

	always_comb begin
		t_val = 9'(signed'({2'b00, code_limit_q}) - signed'({5'd0, jv_q}) - 9'sd2
			- signed'({4'd0, quant_bits_q}));
		em_k  = em_q >> k_q;
		if (signed'({1'b0, em_k}) < signed'({t_val[8], t_val})) begin
			u_sel = 7'(em_k);
			w_sel = k_q;
			p_sel = 32'(em_q) & ((32'd1 << k_q) - 32'd1);
		end else begin
			u_sel = t_val[8] ? 7'd0 : 7'(t_val);
			w_sel = quant_bits_q;
			p_sel = (32'(em_q) - 32'd1) & 32'((33'd1 << quant_bits_q) - 33'd1);
		end
		word = 32'((33'd1 << w_sel) | {1'b0, p_sel});
		glen = 8'(u_sel) + 8'd1 + 8'(w_sel);
	end

	logic [7:0] rx8;
	assign rx8 = 8'(rx_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic [24:0] esum_add;
	assign esum_add = {1'b0, esum_q[qc]} + 25'((em_q + 9'd1 - 9'(ri_q)) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			near_q       <= 8'd0;
			err_range_q  <= 9'd256;
			max_value_q  <= 8'd255;
			quant_bits_q <= 5'd8;
			code_limit_q <= 7'd32;
			halve_q      <= 8'd64;
			accum_init_q <= 8'd4;
			run_value_q  <= '0;
			run_count_q  <= '0;
			run_index_q  <= '0;
			esum_q[0] <= 24'd4; esum_q[1] <= 24'd4;
			occ_q[0]  <= 8'd1;  occ_q[1]  <= 8'd1;
			neg_q[0]  <= 8'd0;  neg_q[1]  <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NEAR:       near_q       <= cfg_data[7:0];
					CFG_ERR_RANGE:  err_range_q  <= cfg_data;
					CFG_MAX_VALUE:  max_value_q  <= cfg_data[7:0];
					CFG_QUANT_BITS: quant_bits_q <= cfg_data[4:0];
					CFG_CODE_LIMIT: code_limit_q <= cfg_data[6:0];
					CFG_HALVE_THR:  halve_q      <= cfg_data[7:0];
					CFG_ACCUM_INIT: accum_init_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && !emit_c) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.action) begin
							run_value_q <= '0; run_count_q <= '0; run_index_q <= '0;
							esum_q[0] <= 24'(accum_init_q); esum_q[1] <= 24'(accum_init_q);
							occ_q[0] <= 8'd1; occ_q[1] <= 8'd1;
							neg_q[0] <= 8'd0; neg_q[1] <= 8'd0;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (in_q.run_start) run_value_q <= ra;
					if (match) begin
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							out_q.recon <= rv_eff;
							out_q.run_ended <= in_q.end_of_line;
							out_q.last <= 1'b1;
							out_q.code_bits <= {31'd0, run_bit};
							out_q.code_length <= {5'd0, run_bit};
							if (run_roll && run_index_q != 5'd31) run_index_q <= run_index_q + 5'd1;
							run_count_q <= in_q.end_of_line ? 16'd0 : 16'(cnt_left);
							state_q <= S_IDLE;
						end
					end else begin
						if (in_q.run_start) run_count_q <= '0;
						jv_q <= order_j(run_index_q);
						ri_q <= (ra == rb);
						if (ra == rb) begin
							err_q <= 11'(signed'({3'd0, ix}) - signed'({3'd0, ra}));
							neg_sign_q <= 1'b0;
						end else if (ra > rb) begin
							err_q <= 11'(signed'({3'd0, rb}) - signed'({3'd0, ix}));
							neg_sign_q <= 1'b1;
						end else begin
							err_q <= 11'(signed'({3'd0, ix}) - signed'({3'd0, rb}));
							neg_sign_q <= 1'b0;
						end
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					tail_q.code_bits <= 32'((in_q.run_start ? 16'd0 : run_count_q)
						& 16'((17'd1 << jv_q) - 17'd1));
					tail_q.code_length <= 6'd1 + 6'(jv_q);
					if (near_q == 8'd0) begin
						rx_q <= 11'(ix);
						state_q <= S_MOD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						logic signed [10:0] qv;
						logic signed [19:0] rxw;
						qv = err_q > 0 ? 11'(div_quot) : -11'(div_quot);
						rxw = 20'(signed'({12'd0, ri_q ? ra : rb}))
							+ (neg_sign_q ? -20'(qv) : 20'(qv)) * 20'(signed'({11'd0, div_d}));
						err_q <= qv;
						if (rxw < 0) rx_q <= 11'd0;
						else if (rxw > 20'(max_value_q)) rx_q <= 11'(max_value_q);
						else rx_q <= 11'(rxw);
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					logic signed [11:0] e2;
					e2 = 12'(err_q);
					if (e2 < 0) e2 = e2 + 12'(err_range_q);
					if (e2 >= signed'(12'((10'(err_range_q) + 10'd1) >> 1)))
						e2 = e2 - 12'(err_range_q);
					err_q <= 11'(e2);
					temp_q <= ri_q ? {1'b0, esum_q[1]} + 25'(occ_q[1] >> 1) : {1'b0, esum_q[0]};
					occ_sh_q <= 32'(occ_q[ri_q]);
					k_q <= 5'd0;
					state_q <= S_KSRCH;
				end
				S_KSRCH: begin
					if (k_q < 5'(K_MAX) && 33'(occ_sh_q) < 33'(temp_q)) begin
						k_q <= k_q + 5'd1;
						occ_sh_q <= occ_sh_q << 1;
					end else begin
						em_q <= em_c;
						state_q <= S_CODE;
					end
				end
				S_CODE: begin
					gcode_q.code_bits <= word;
					gcode_q.code_length <= glen > 8'd32 ? 6'd32 : 6'(glen);
					if (occ_q[qc] >= halve_q) begin
						esum_q[qc] <= (esum_add > 25'(SUM_MAX) ? SUM_MAX : 24'(esum_add)) >> 1;
						occ_q[qc] <= (occ_q[qc] >> 1) + 8'd1;
						neg_q[qc] <= ((err_q < 0 && neg_q[qc] != 8'd255) ?
							neg_q[qc] + 8'd1 : neg_q[qc]) >> 1;
					end else begin
						esum_q[qc] <= esum_add > 25'(SUM_MAX) ? SUM_MAX : 24'(esum_add);
						occ_q[qc] <= occ_q[qc] + 8'd1;
						if (err_q < 0 && neg_q[qc] != 8'd255) neg_q[qc] <= neg_q[qc] + 8'd1;
					end
					if (run_index_q != 5'd0) run_index_q <= run_index_q - 5'd1;
					run_count_q <= '0;
					state_q <= S_OUT1;
				end
				S_OUT1: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q <= '{code_bits: tail_q.code_bits, code_length: tail_q.code_length,
							recon: rx8, run_ended: 1'b1, last: 1'b0};
						state_q <= S_OUT2;
					end
				end
				S_OUT2: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q <= '{code_bits: gcode_q.code_bits, code_length: gcode_q.code_length,
							recon: rx8, run_ended: 1'b1, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) in_q <= in_data;
	end

	`JRM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "word changed while stalled")
	`JRM_ASSERT_NEXT(a_out2_last, clk, arst_n, (state_q == S_OUT2) && (!out_valid_q || out_ready),
		out_valid && out_data.last, "second word missing last")
	`JRM_ASSERT_NEXT(a_out1_notlast, clk, arst_n, (state_q == S_OUT1) && (!out_valid_q || out_ready),
		out_valid && !out_data.last && out_data.run_ended, "tail word malformed")
	`JRM_ASSERT_IMP(a_len_max, clk, arst_n, out_valid, out_data.code_length <= 6'd32,
		"code length over 32")
endmodule
`default_nettype wire
